### rtl/combined_lcg_shuffle_rng_defines.svh
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng_defines
// assertion macros used by the generator top level; clock is clk, reset is rst
// ----------------------------------------------------------------------------
`ifndef COMBINED_LCG_SHUFFLE_RNG_DEFINES_SVH
`define COMBINED_LCG_SHUFFLE_RNG_DEFINES_SVH

// same-cycle implication
`define CLSR_ASSERT_IMPLY(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define CLSR_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

### rtl/clsr_pkg.sv
// ----------------------------------------------------------------------------
// clsr_pkg
// types and fixed constants of the combined lcg / shuffle table generator
// ----------------------------------------------------------------------------
package clsr_pkg;

  localparam logic [31:0] MOD1     = 32'd2147483563;
  localparam logic [31:0] MOD2     = 32'd2147483399;
  localparam logic [31:0] MOD1M1   = 32'd2147483562;
  localparam logic [31:0] FRAC_CAP = 32'd4294966780;

  localparam logic [15:0] MUL1     = 16'd40014;
  localparam logic [15:0] MUL2     = 16'd40692;
  // 2^32 / MOD1 = 2 + 170 / MOD1
  localparam logic [15:0] FRAC_MUL = 16'd170;

  // 2^31 minus each modulus
  localparam logic [7:0]  FOLD1    = 8'd85;
  localparam logic [7:0]  FOLD2    = 8'd249;

  localparam logic [30:0] GEN1_INIT = 31'd1;
  localparam logic [30:0] GEN2_INIT = 31'd123456789;

  typedef struct packed {
    logic        kind;
    logic [30:0] seed;
  } in_t;

  typedef struct packed {
    logic [30:0] draw;
    logic [31:0] fraction;
  } out_t;

  typedef struct packed {
    logic        load;
    logic        sel_mod2;
    logic [30:0] operand;
    logic [15:0] mult;
  } mm_req_t;

  typedef struct packed {
    logic [30:0] rem;
    logic [15:0] hi;
    logic        wrap;
  } mm_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WARM_MUL,
    S_WARM_FOLD,
    S_GEN1_MUL,
    S_GEN1_FOLD,
    S_GEN2_FOLD,
    S_DIV_WAIT,
    S_READ,
    S_UPDATE,
    S_FRAC_MUL,
    S_FRAC_FOLD
  } state_t;

endpackage

### rtl/clsr_mulmod.sv
// ----------------------------------------------------------------------------
// clsr_mulmod
// shared multiply unit: registered 31x16 product, then fold modulo 2^31 - c
// ----------------------------------------------------------------------------
module clsr_mulmod (
  input  logic               clk,
  input  clsr_pkg::mm_req_t  req,
  output clsr_pkg::mm_rsp_t  rsp
);

  logic [46:0] prod;
  logic        sel_q;
  logic [15:0] hi;
  logic [30:0] lo;
  logic [7:0]  fold_c;
  logic [31:0] modulus;
  logic [23:0] hic;
  logic [31:0] t;
  logic [31:0] diff;

  always_ff @(posedge clk) begin
    if (req.load) begin
      prod  <= 47'(req.operand) * 47'(req.mult);
      sel_q <= req.sel_mod2;
    end
  end

  // p = hi*2^31 + lo = hi*m + (hi*c + lo), and hi*c + lo < 2m
  always_comb begin
    hi      = prod[46:31];
    lo      = prod[30:0];
    fold_c  = sel_q ? clsr_pkg::FOLD2 : clsr_pkg::FOLD1;
    modulus = sel_q ? clsr_pkg::MOD2 : clsr_pkg::MOD1;
    hic     = {8'b0, hi} * {16'b0, fold_c};
    t       = {8'b0, hic} + {1'b0, lo};
    diff    = t - modulus;
    rsp.wrap = (t >= modulus);
    rsp.hi   = hi;
    rsp.rem  = rsp.wrap ? diff[30:0] : t[30:0];
  end

endmodule

### rtl/clsr_idxdiv.sv
// ----------------------------------------------------------------------------
// clsr_idxdiv
// table index: last output divided by the bucket size, reciprocal estimate
// registered on start, then a single compare and correct in the next
// ----------------------------------------------------------------------------
module clsr_idxdiv #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [30:0]                    dividend,
  output logic                           done,
  output logic [$clog2(TABLE_DEPTH)-1:0] idx
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int QW = IW + 1;
  localparam int PW = 31 + QW;
  localparam logic [30:0] BUCKET =
    31'(64'd1 + 64'(clsr_pkg::MOD1M1) / 64'(TABLE_DEPTH));
  // floor(2^31 / BUCKET): the estimate is the quotient or one below it
  localparam logic [QW-1:0] RECIP = QW'(64'h8000_0000 / 64'(BUCKET));

  logic [30:0]   num;
  logic [QW-1:0] q_est;
  logic [QW-1:0] quo;
  logic          busy;
  logic [PW-1:0] est_prod;
  logic [PW-1:0] back_prod;
  logic [PW-1:0] part_rem;
  logic          ge;

  assign est_prod  = PW'(dividend) * PW'(RECIP);
  assign back_prod = PW'(q_est) * PW'(BUCKET);
  // remainder of the estimate is below two buckets
  assign part_rem  = PW'(num) - back_prod;
  assign ge        = (part_rem >= PW'(BUCKET));
  assign done      = !busy;
  // clamp kept as a safeguard
  assign idx  = (quo >= QW'(TABLE_DEPTH)) ? IW'(TABLE_DEPTH - 1) : quo[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num   <= dividend;
      q_est <= est_prod[PW-1:31];
    end else if (busy) begin
      quo <= q_est + QW'(ge);
    end
  end

endmodule

### rtl/clsr_table.sv
// ----------------------------------------------------------------------------
// clsr_table
// shuffle table memory, one write and one registered read port, valid bits
// ----------------------------------------------------------------------------
module clsr_table #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  input  logic [30:0]                    wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  output logic [30:0]                    rd_data
);

  logic [30:0]            mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld;
  logic [30:0]            rd_q;
  logic                   rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  // never-written entries read as zero
  assign rd_data = rd_vld ? rd_q : '0;

endmodule

### rtl/combined_lcg_shuffle_rng.sv
// Draw: output valid after accept, independent of TABLE_DEPTH;
// next transaction taken after the result is loaded, later while output stalls.
// Reseed adds a warm-up whose length grows with TABLE_DEPTH.
// Rate is set by the state sequence that shares the multiply/fold unit.
// Reset (rst, synchronous) restores generator state and marks the table all zero.
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng
// combined two-lcg generator with a shuffle table, one result per transaction
// ----------------------------------------------------------------------------
`include "combined_lcg_shuffle_rng_defines.svh"

module combined_lcg_shuffle_rng #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  clsr_pkg::in_t   in_item,
  output logic            out_valid,
  input  logic            out_stall,
  output clsr_pkg::out_t  out_item
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int JW = $clog2(TABLE_DEPTH + 8);

  clsr_pkg::state_t  state, state_next;
  clsr_pkg::mm_req_t mm_req;
  clsr_pkg::mm_rsp_t mm_rsp;

  logic [30:0]   first_gen;
  logic [30:0]   second_gen;
  logic [30:0]   last_out;
  logic [JW-1:0] warm_cnt;

  logic          accept;
  logic          out_free;
  logic [30:0]   seed_eff;

  logic          div_start;
  logic          div_done;
  logic [IW-1:0] div_idx;

  logic          tbl_wr_en;
  logic [IW-1:0] tbl_wr_addr;
  logic [30:0]   tbl_wr_data;
  logic          tbl_rd_en;
  logic [30:0]   tbl_rd_data;

  logic          gen1_upd;
  logic          gen2_upd;
  logic          warm_dec;
  logic          warm_last;
  logic          last_upd;
  logic          out_load;

  logic [31:0]   diff;
  logic [31:0]   y_fix;
  logic [32:0]   frac_sum;
  logic [31:0]   frac_val;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != clsr_pkg::S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign seed_eff = (in_item.seed == '0) ? 31'd1 : in_item.seed;

  clsr_mulmod u_mulmod (
    .clk (clk),
    .req (mm_req),
    .rsp (mm_rsp)
  );

  clsr_idxdiv #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_idxdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (last_out),
    .done     (div_done),
    .idx      (div_idx)
  );

  clsr_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (div_idx),
    .rd_data (tbl_rd_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      clsr_pkg::S_IDLE: begin
        if (accept) begin
          state_next = in_item.kind ? clsr_pkg::S_WARM_MUL : clsr_pkg::S_GEN1_MUL;
        end
      end
      clsr_pkg::S_WARM_MUL:  state_next = clsr_pkg::S_WARM_FOLD;
      clsr_pkg::S_WARM_FOLD: begin
        state_next = (warm_cnt == '0) ? clsr_pkg::S_GEN1_MUL : clsr_pkg::S_WARM_MUL;
      end
      clsr_pkg::S_GEN1_MUL:  state_next = clsr_pkg::S_GEN1_FOLD;
      clsr_pkg::S_GEN1_FOLD: state_next = clsr_pkg::S_GEN2_FOLD;
      clsr_pkg::S_GEN2_FOLD: state_next = clsr_pkg::S_DIV_WAIT;
      clsr_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          state_next = clsr_pkg::S_READ;
        end
      end
      clsr_pkg::S_READ:      state_next = clsr_pkg::S_UPDATE;
      clsr_pkg::S_UPDATE:    state_next = clsr_pkg::S_FRAC_MUL;
      clsr_pkg::S_FRAC_MUL:  state_next = clsr_pkg::S_FRAC_FOLD;
      clsr_pkg::S_FRAC_FOLD: begin
        if (out_free) begin
          state_next = clsr_pkg::S_IDLE;
        end
      end
      default:               state_next = clsr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mm_req      = '0;
    div_start   = 1'b0;
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = div_idx;
    tbl_wr_data = first_gen;
    tbl_rd_en   = 1'b0;
    gen1_upd    = 1'b0;
    gen2_upd    = 1'b0;
    warm_dec    = 1'b0;
    warm_last   = 1'b0;
    last_upd    = 1'b0;
    out_load    = 1'b0;
    unique case (state)
      clsr_pkg::S_IDLE: begin
      end
      clsr_pkg::S_WARM_MUL: begin
        mm_req.load    = 1'b1;
        mm_req.operand = first_gen;
        mm_req.mult    = clsr_pkg::MUL1;
      end
      clsr_pkg::S_WARM_FOLD: begin
        gen1_upd  = 1'b1;
        warm_dec  = (warm_cnt != '0);
        warm_last = (warm_cnt == '0);
        // only the last TABLE_DEPTH warm-up values land in the table
        if (warm_cnt < JW'(TABLE_DEPTH)) begin
          tbl_wr_en   = 1'b1;
          tbl_wr_addr = warm_cnt[IW-1:0];
          tbl_wr_data = mm_rsp.rem;
        end
      end
      clsr_pkg::S_GEN1_MUL: begin
        mm_req.load    = 1'b1;
        mm_req.operand = first_gen;
        mm_req.mult    = clsr_pkg::MUL1;
        div_start      = 1'b1;
      end
      clsr_pkg::S_GEN1_FOLD: begin
        gen1_upd        = 1'b1;
        mm_req.load     = 1'b1;
        mm_req.sel_mod2 = 1'b1;
        mm_req.operand  = second_gen;
        mm_req.mult     = clsr_pkg::MUL2;
      end
      clsr_pkg::S_GEN2_FOLD: begin
        gen2_upd = 1'b1;
      end
      clsr_pkg::S_DIV_WAIT: begin
      end
      clsr_pkg::S_READ: begin
        tbl_rd_en = 1'b1;
      end
      clsr_pkg::S_UPDATE: begin
        tbl_wr_en = 1'b1;
        last_upd  = 1'b1;
      end
      clsr_pkg::S_FRAC_MUL: begin
        mm_req.load    = 1'b1;
        mm_req.operand = last_out;
        mm_req.mult    = clsr_pkg::FRAC_MUL;
      end
      clsr_pkg::S_FRAC_FOLD: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // table entry minus second generator, wrapped into 1..MOD1-1
  always_comb begin
    diff  = {1'b0, tbl_rd_data} - {1'b0, second_gen};
    y_fix = (diff[31] || (diff == '0)) ? (diff + clsr_pkg::MOD1M1) : diff;
  end

  // floor(L*2^32/MOD1) = 2L + floor(170L/MOD1)
  always_comb begin
    frac_sum = {1'b0, last_out, 1'b0} + 33'(mm_rsp.hi) + 33'(mm_rsp.wrap);
    frac_val = (frac_sum > {1'b0, clsr_pkg::FRAC_CAP}) ? clsr_pkg::FRAC_CAP
                                                        : frac_sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= clsr_pkg::S_IDLE;
      first_gen  <= clsr_pkg::GEN1_INIT;
      second_gen <= clsr_pkg::GEN2_INIT;
      last_out   <= '0;
      warm_cnt   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && in_item.kind) begin
        first_gen  <= seed_eff;
        second_gen <= seed_eff;
        warm_cnt   <= JW'(TABLE_DEPTH + 7);
      end else begin
        if (gen1_upd) begin
          first_gen <= mm_rsp.rem;
        end
        if (gen2_upd) begin
          second_gen <= mm_rsp.rem;
        end
        if (warm_dec) begin
          warm_cnt <= warm_cnt - 1'b1;
        end
      end
      if (last_upd) begin
        last_out <= y_fix[30:0];
      end else if (warm_last) begin
        last_out <= mm_rsp.rem;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.draw     <= last_out;
      out_item.fraction <= frac_val;
    end
  end

  `CLSR_ASSERT_IMPLY(a_draw_range, out_valid, (out_item.draw != '0) && (32'(out_item.draw) < clsr_pkg::MOD1), "draw outside 1..MOD1-1")
  `CLSR_ASSERT_IMPLY(a_frac_cap, out_valid, out_item.fraction <= clsr_pkg::FRAC_CAP, "fraction above cap")
  `CLSR_ASSERT_IMPLY(a_gen1_reduced, state == clsr_pkg::S_GEN1_MUL, 32'(first_gen) < clsr_pkg::MOD1, "first generator not reduced")
  `CLSR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "intake open right after a transaction")

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the combined lcg / shuffle table generator against a cycle-free model
// of both generators and the shuffle table, under random sender bursts and
// receiver stalls; every transaction is predicted at acceptance and each
// result is compared in order, field by field
// ----------------------------------------------------------------------------
module testbench;

  localparam int          DEPTH          = 32;
  localparam logic [31:0] MOD_A          = 32'd2147483563;
  localparam logic [31:0] MOD_B          = 32'd2147483399;
  localparam logic [15:0] MUL_A          = 16'd40014;
  localparam logic [15:0] MUL_B          = 16'd40692;
  localparam longint      MOD_A_LESS_ONE = 64'd2147483562;
  localparam logic [31:0] BUCKET_SPAN    = 32'd2147483562 / DEPTH + 32'd1;
  localparam logic [63:0] FRAC_LIMIT     = 64'd4294966780;
  localparam logic [30:0] SEED_MAX       = 31'h7FFFFFFF;
  localparam int          RANDOM_ITEMS   = 800;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          DRAIN_CYCLES   = 40;

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  clsr_pkg::in_t   in_item   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  clsr_pkg::out_t  out_item;

  // model of the generator state
  logic [30:0] gen1_q;
  logic [30:0] gen2_q;
  logic [30:0] last_draw_q;
  logic [30:0] shuffle_q [DEPTH];

  clsr_pkg::out_t expected_draws[$];
  int mismatch_count = 0;
  int burst_left     = 0;
  int quiet_cycles   = 0;
  int cycle_count    = 0;
  int stall_mode     = 0;

  combined_lcg_shuffle_rng #(
    .TABLE_DEPTH(DEPTH)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #4 clk = ~clk;

  function automatic logic [30:0] lcg_next(input logic [30:0] x, input logic [15:0] mul,
                                           input logic [31:0] modulus);
    logic [63:0] prod;
    prod = 64'(x) * 64'(mul);
    return 31'(prod % 64'(modulus));
  endfunction

  function automatic void clear_generator();
    gen1_q      = 31'd1;
    gen2_q      = 31'd123456789;
    last_draw_q = '0;
    for (int i = 0; i < DEPTH; i++) shuffle_q[i] = '0;
  endfunction

  // advances the model by one transaction and returns the draw it gives
  function automatic clsr_pkg::out_t advance_generator(input clsr_pkg::in_t item);
    logic [30:0]    start;
    int unsigned    slot;
    longint         diff;
    logic [63:0]    scaled;
    clsr_pkg::out_t res;
    if (item.kind) begin
      start  = (item.seed == '0) ? 31'd1 : item.seed;
      gen1_q = start;
      gen2_q = start;
      // warm-up: the last DEPTH steps fill the table from the top down
      for (int j = DEPTH + 7; j >= 0; j--) begin
        gen1_q = lcg_next(gen1_q, MUL_A, MOD_A);
        if (j < DEPTH) shuffle_q[j] = gen1_q;
      end
      last_draw_q = shuffle_q[0];
    end
    gen1_q = lcg_next(gen1_q, MUL_A, MOD_A);
    gen2_q = lcg_next(gen2_q, MUL_B, MOD_B);
    slot = 32'(last_draw_q) / BUCKET_SPAN;
    if (slot >= DEPTH) slot = DEPTH - 1;
    diff = longint'(shuffle_q[slot]) - longint'(gen2_q);
    shuffle_q[slot] = gen1_q;
    if (diff < 1) diff = diff + MOD_A_LESS_ONE;
    last_draw_q = diff[30:0];
    scaled = (64'(last_draw_q) << 32) / 64'(MOD_A);
    if (scaled > FRAC_LIMIT) scaled = FRAC_LIMIT;
    res.draw     = last_draw_q;
    res.fraction = scaled[31:0];
    return res;
  endfunction

  // predict on input transactions, compare on output transactions
  always @(posedge clk) begin : scoreboard
    clsr_pkg::out_t want;
    if (rst) begin
      clear_generator();
    end else begin
      if (in_valid && !in_stall) expected_draws.push_back(advance_generator(in_item));
      if (out_valid && !out_stall) begin
        if (expected_draws.size() == 0) begin
          $error("result with none expected: draw %0d fraction %0d",
                 out_item.draw, out_item.fraction);
          mismatch_count++;
        end else begin
          want = expected_draws.pop_front();
          if (out_item.draw !== want.draw) begin
            $error("draw: expected %0d, actual %0d", want.draw, out_item.draw);
            mismatch_count++;
          end
          if (out_item.fraction !== want.fraction) begin
            $error("fraction: expected %0d, actual %0d", want.fraction, out_item.fraction);
            mismatch_count++;
          end
        end
      end
    end
  end

  // receiver: free-running, random, and square-wave stall phases
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 256 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_stall <= cycle_count[4];
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL combined_lcg_shuffle_rng");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one transaction; valid stays high inside a burst, drops for the gaps between
  task automatic send_item(input logic kind, input logic [30:0] seed);
    int gap;
    in_item  <= clsr_pkg::in_t'{kind: kind, seed: seed};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(1, 20);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic test_draws_from_reset();
    // first draw sees the table still all zero and indexes from a zero last value
    for (int i = 0; i < 4; i++) send_item(1'b0, 31'($urandom));
  endtask

  task automatic test_seed_extremes();
    send_item(1'b1, 31'd0);
    send_item(1'b0, 31'd0);
    send_item(1'b1, 31'd1);
    send_item(1'b0, SEED_MAX);
    send_item(1'b1, SEED_MAX);
    send_item(1'b0, SEED_MAX);
    send_item(1'b1, 31'h40000000);
    send_item(1'b0, 31'd0);
  endtask

  task automatic test_modulus_seeds();
    // the first two seeds each pin one generator at zero for good
    send_item(1'b1, MOD_A[30:0]);
    for (int i = 0; i < 3; i++) send_item(1'b0, 31'($urandom));
    send_item(1'b1, MOD_B[30:0]);
    for (int i = 0; i < 3; i++) send_item(1'b0, 31'($urandom));
    send_item(1'b1, MOD_A[30:0] - 31'd1);
    send_item(1'b0, 31'd0);
  endtask

  task automatic test_random_stream();
    logic [30:0] seed;
    logic        kind;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = ($urandom_range(0, 15) == 0);
      case ($urandom_range(0, 9))
        0:       seed = 31'd0;
        1:       seed = SEED_MAX;
        2:       seed = MOD_A[30:0];
        3:       seed = MOD_B[30:0];
        4:       seed = 31'($urandom_range(1, 255));
        default: seed = 31'($urandom);
      endcase
      send_item(kind, seed);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_draws_from_reset();
    test_seed_extremes();
    test_modulus_seeds();
    test_random_stream();
    in_valid <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS combined_lcg_shuffle_rng");
    end else begin
      $display("FAIL combined_lcg_shuffle_rng");
    end
    $finish;
  end

endmodule
